[hdl/lslc_pkg.sv]
// Shared widths, constants and handshake structs of the lux conditioner.
`timescale 1ns / 1ps
package lslc_pkg;

  localparam int ADC_W        = 12;
  localparam int FULL_SCALE   = (1 << ADC_W) - 1;
  localparam int CNT_W        = 8;
  localparam int ACC_W        = ADC_W + CNT_W;
  localparam int REF_W        = 13;
  localparam int UV_W         = 23;
  localparam int LUX_W        = 24;
  localparam int MEAN_W       = 16;
  localparam int MEAN_FRAC    = 4;
  localparam int QUAL_W       = 7;
  localparam int DEN_W        = CNT_W + ADC_W;
  localparam int UV_PER_MV    = 1000;
  localparam int UV_PER_MV_W  = 10;
  localparam int PROD1_W      = ACC_W + REF_W;
  localparam int PROD2_W      = PROD1_W + UV_PER_MV_W;
  localparam int QK_W         = 7;
  localparam int QPROD_W      = ACC_W + QK_W;

  localparam int Q_SCALE      = 100;
  localparam int Q_LOW        = 50;
  localparam int Q_HIGH       = 80;
  localparam int Q_LOW_DIV    = 100;
  localparam int Q_HIGH_NUM   = 20;
  localparam int Q_HIGH_DEN   = 19;
  localparam int Q_HIGH_W     = 5;

  localparam int FILTER_DEPTH = 8;
  localparam int HIDX_W       = $clog2(FILTER_DEPTH);
  localparam int HSUM_W       = LUX_W + HIDX_W;

  localparam int DIV_W        = PROD2_W;
  localparam int DVS_W        = UV_W;
  localparam int STEP_W       = $clog2(DIV_W);

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = UV_W;

  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd3;

  localparam logic [CNT_W-1:0] OVS_RESET  = 8'd1;
  localparam logic [REF_W-1:0] REF_RESET  = 13'd3300;
  localparam logic [UV_W-1:0]  DARK_RESET = 23'd0;
  localparam logic [UV_W-1:0]  SENS_RESET = 23'd3300;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [LUX_W-1:0] lux;
  } hist_req_t;

  typedef struct packed {
    logic             done;
    logic [LUX_W-1:0] filtered;
  } hist_rsp_t;

endpackage

[hdl/lslc_if.sv]
// Valid/ready channel interfaces for input codes, readings and register writes.
`timescale 1ns / 1ps
interface lslc_in_if;
  logic                      valid;
  logic                      ready;
  logic [lslc_pkg::ADC_W-1:0] adc_code;
  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface lslc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lslc_pkg::MEAN_W-1:0] mean_code;
  logic [lslc_pkg::UV_W-1:0]   voltage_uv;
  logic [lslc_pkg::LUX_W-1:0]  filtered_lux;
  logic [lslc_pkg::QUAL_W-1:0] quality;
  logic                        reading_valid;
  modport source (output valid, output mean_code, output voltage_uv, output filtered_lux,
                  output quality, output reading_valid, input ready);
  modport sink   (input valid, input mean_code, input voltage_uv, input filtered_lux,
                  input quality, input reading_valid, output ready);
endinterface

interface lslc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lslc_pkg::CFG_IDX_W-1:0]  index;
  logic [lslc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/lslc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all readings.
`timescale 1ns / 1ps
module lslc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lslc_pkg::div_req_t req,
  output lslc_pkg::div_rsp_t rsp
);
  import lslc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[hdl/lslc_hist.sv]
// Lux history ring in a synchronous memory with running sum and moving average.
`timescale 1ns / 1ps
module lslc_hist (
  input  logic                clk,
  input  logic                rst_n,
  input  lslc_pkg::hist_req_t req,
  output lslc_pkg::hist_rsp_t rsp
);
  import lslc_pkg::*;

  logic [LUX_W-1:0]        mem [FILTER_DEPTH];
  logic [FILTER_DEPTH-1:0] hvalid_r;
  logic [HIDX_W-1:0]       idx_r;
  logic [HIDX_W-1:0]       idx_nxt;
  logic [LUX_W-1:0]        rd_r;
  logic                    rd_ok_r;
  logic                    wr_r;
  logic                    done_r;
  logic [HSUM_W-1:0]       hsum_r;
  logic [HSUM_W-1:0]       hsum_nxt;
  logic [LUX_W-1:0]        old_lux;

  // never-written entries read as zero
  assign old_lux  = rd_ok_r ? rd_r : '0;
  assign hsum_nxt = hsum_r - HSUM_W'(old_lux) + HSUM_W'(req.lux);
  assign idx_nxt  = (idx_r == HIDX_W'(FILTER_DEPTH - 1)) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_r) begin
      mem[idx_r] <= req.lux;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      idx_r    <= '0;
      rd_ok_r  <= 1'b0;
      wr_r     <= 1'b0;
      done_r   <= 1'b0;
      hsum_r   <= '0;
    end else begin
      rd_ok_r <= hvalid_r[idx_r];
      wr_r    <= req.start;
      done_r  <= wr_r;
      if (wr_r) begin
        hsum_r          <= hsum_nxt;
        hvalid_r[idx_r] <= 1'b1;
        idx_r           <= idx_nxt;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.filtered = LUX_W'(hsum_r / HSUM_W'(FILTER_DEPTH));

endmodule

[hdl/light_sensor_lux_conditioner.sv]
// Top level: code accumulation, reading sequencer, config registers and output register.
//
// ADC codes are taken one per cycle while the block gathers a reading. The item that
// completes a reading starts a sequencer that runs four divisions (mean, voltage, lux,
// quality) on one shared bit-serial divider of 43 steps each, plus a read-modify-write
// of the lux history memory; the lux division is skipped when lux is forced to zero
// or full scale, and the block takes no code until the reading is loaded into the
// output register. A finished reading waits in that register, and gathering of the
// next reading goes on meanwhile. The history starts at zero after reset through
// per-entry valid bits, with no clearing pass. Register writes are taken at any time
// and are meant for idle periods.
`timescale 1ns / 1ps
module light_sensor_lux_conditioner (
  input  logic        clk,
  input  logic        rst_n,
  lslc_in_if.sink     in_if,
  lslc_out_if.source  out_if,
  lslc_cfg_if.sink    cfg_if
);
  import lslc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_MEAN = 4'd2;
  localparam logic [3:0] ST_VOLT = 4'd3;
  localparam logic [3:0] ST_LUXS = 4'd4;
  localparam logic [3:0] ST_LUX  = 4'd5;
  localparam logic [3:0] ST_QS   = 4'd6;
  localparam logic [3:0] ST_QUAL = 4'd7;
  localparam logic [3:0] ST_HIST = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;

  logic [CNT_W-1:0]   ovs_r;
  logic [REF_W-1:0]   ref_r;
  logic [UV_W-1:0]    dark_r;
  logic [UV_W-1:0]    sens_r;

  logic [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   acc_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   target;
  logic               in_fire;
  logic               last_code;

  logic [ACC_W-1:0]   sum_r;
  logic [CNT_W-1:0]   n_r;
  logic [DEN_W-1:0]   denom_r;
  logic [PROD1_W-1:0] prod1_r;
  logic [PROD2_W-1:0] prod2_r;
  logic [QK_W-1:0]    qk_r;
  logic [QPROD_W-1:0] qprod_r;
  logic [QPROD_W-1:0] s100;
  logic [ACC_W+4:0]   s20;
  logic [ACC_W+4:0]   d19;

  logic [MEAN_W-1:0]  mean_r;
  logic [UV_W-1:0]    volt_r;
  logic [LUX_W-1:0]   lux_r;
  logic [QUAL_W-1:0]  qual_r;
  logic [UV_W-1:0]    comp;

  logic               out_valid_r;
  logic [MEAN_W-1:0]  out_mean_r;
  logic [UV_W-1:0]    out_volt_r;
  logic [LUX_W-1:0]   out_lux_r;
  logic [QUAL_W-1:0]  out_qual_r;
  logic               out_load;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  hist_req_t hist_req;
  hist_rsp_t hist_rsp;

  lslc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lslc_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rsp   (hist_rsp)
  );

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovs_r  <= OVS_RESET;
      ref_r  <= REF_RESET;
      dark_r <= DARK_RESET;
      sens_r <= SENS_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_OVERSAMPLE:  ovs_r  <= cfg_if.data[CNT_W-1:0];
        REG_REFERENCE:   ref_r  <= cfg_if.data[REF_W-1:0];
        REG_DARK_OFFSET: dark_r <= cfg_if.data[UV_W-1:0];
        REG_SENSITIVITY: sens_r <= cfg_if.data[UV_W-1:0];
      endcase
    end
  end

  // code gathering
  assign target    = (ovs_r == '0) ? CNT_W'(1) : ovs_r;
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire   = in_if.valid && in_if.ready;
  assign acc_inc   = acc_r + ACC_W'(in_if.adc_code);
  assign cnt_inc   = cnt_r + 1'b1;
  assign last_code = cnt_inc >= target;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (in_fire) begin
      acc_r <= last_code ? '0 : acc_inc;
      cnt_r <= last_code ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_code) begin
      sum_r <= acc_inc;
      n_r   <= cnt_inc;
    end
  end

  // product pipeline; settles well before the mean division ends
  assign s100 = QPROD_W'(sum_r) * QPROD_W'(Q_LOW_DIV);
  assign s20  = (ACC_W+5)'(sum_r) * Q_HIGH_W'(Q_HIGH_NUM);
  assign d19  = (ACC_W+5)'(denom_r) * Q_HIGH_W'(Q_HIGH_DEN);

  always_ff @(posedge clk) begin
    denom_r <= DEN_W'(n_r) * DEN_W'(FULL_SCALE);
    prod1_r <= PROD1_W'(sum_r) * PROD1_W'(ref_r);
    prod2_r <= PROD2_W'(prod1_r) * PROD2_W'(UV_PER_MV);
    if (s20 > d19) begin
      qk_r <= QK_W'(Q_HIGH);
    end else if (s100 < QPROD_W'(denom_r)) begin
      qk_r <= QK_W'(Q_LOW);
    end else begin
      qk_r <= QK_W'(Q_SCALE);
    end
    qprod_r <= QPROD_W'(sum_r) * QPROD_W'(qk_r);
  end

  assign comp = volt_r - dark_r;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    hist_req.start   = 1'b0;
    hist_req.lux     = lux_r;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && last_code) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({sum_r, {MEAN_FRAC{1'b0}}});
        div_req.divisor  = DVS_W'(n_r);
        state_nxt        = ST_MEAN;
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = prod2_r;
          div_req.divisor  = DVS_W'(denom_r);
          state_nxt        = ST_VOLT;
        end
      end
      ST_VOLT: begin
        if (div_rsp.done) begin
          state_nxt = ST_LUXS;
        end
      end
      ST_LUXS: begin
        if (volt_r <= dark_r || sens_r == '0) begin
          state_nxt = ST_QS;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({comp, {MEAN_FRAC{1'b0}}});
          div_req.divisor  = sens_r;
          state_nxt        = ST_LUX;
        end
      end
      ST_LUX: begin
        if (div_rsp.done) begin
          state_nxt = ST_QS;
        end
      end
      ST_QS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(qprod_r);
        div_req.divisor  = DVS_W'(denom_r);
        state_nxt        = ST_QUAL;
      end
      ST_QUAL: begin
        if (div_rsp.done) begin
          hist_req.start = 1'b1;
          state_nxt      = ST_HIST;
        end
      end
      ST_HIST: begin
        if (hist_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (state_r == ST_MEAN && div_rsp.done) begin
      mean_r <= div_rsp.quotient[MEAN_W-1:0];
    end
    if (state_r == ST_VOLT && div_rsp.done) begin
      volt_r <= div_rsp.quotient[UV_W-1:0];
    end
    if (state_r == ST_LUXS) begin
      lux_r <= (volt_r <= dark_r) ? '0 : LUX_MAX;
    end
    if (state_r == ST_LUX && div_rsp.done) begin
      // saturate at full 24-bit scale
      lux_r <= (div_rsp.quotient[DIV_W-1:LUX_W] != '0) ? LUX_MAX
                                                       : div_rsp.quotient[LUX_W-1:0];
    end
    if (state_r == ST_QUAL && div_rsp.done) begin
      qual_r <= (div_rsp.quotient > DIV_W'(Q_SCALE)) ? QUAL_W'(Q_SCALE)
                                                      : div_rsp.quotient[QUAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r <= mean_r;
      out_volt_r <= volt_r;
      out_lux_r  <= hist_rsp.filtered;
      out_qual_r <= qual_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.mean_code     = out_mean_r;
  assign out_if.voltage_uv    = out_volt_r;
  assign out_if.filtered_lux  = out_lux_r;
  assign out_if.quality       = out_qual_r;
  assign out_if.reading_valid = 1'b1;

  // checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
      div_rsp.done |-> (state_r == ST_MEAN || state_r == ST_VOLT ||
                        state_r == ST_LUX || state_r == ST_QUAL))
    else $error("divider finished outside a waiting state");

  a_hist_done_in_hist: assert property (@(posedge clk) disable iff (!rst_n)
      hist_rsp.done |-> state_r == ST_HIST)
    else $error("history update finished outside its state");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r != {CNT_W{1'b1}})
    else $error("sample counter reached its ceiling");

  a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> out_qual_r <= QUAL_W'(Q_SCALE))
    else $error("quality above 100");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_if.ready) |=> $stable(out_lux_r))
    else $error("reading overwritten before it was taken");

endmodule
